[hw/rtl/swlrl_pkg.sv]
`default_nettype none
package swlrl_pkg;

    localparam int CLIENTS    = 8;
    localparam int RING_SLOTS = 1024;
    localparam int RINGS      = CLIENTS * 3;
    localparam int MEM_DEPTH  = RINGS * RING_SLOTS;

    localparam int RING_W = (RINGS > 1) ? $clog2(RINGS) : 1;
    localparam int SLOT_W = $clog2(RING_SLOTS);
    localparam int FILL_W = $clog2(RING_SLOTS + 1);
    localparam int ADDR_W = $clog2(MEM_DEPTH);

    localparam int STAMP_W = 32;
    localparam int LIMIT_W = 11;
    localparam int RETRY_W = 12;
    localparam int CFG_W   = 3;

    localparam logic [STAMP_W-1:0] MINUTE_WIN = STAMP_W'(60);
    localparam logic [STAMP_W-1:0] HOUR_WIN   = STAMP_W'(3600);
    localparam logic [RETRY_W-1:0] RETRY_MAX  = RETRY_W'(3600);

    // operation codes
    localparam logic [1:0] FUNC_CHECK     = 2'd0;
    localparam logic [1:0] FUNC_RECORD    = 2'd1;
    localparam logic [1:0] FUNC_CLR_ONE   = 2'd2;
    localparam logic [1:0] FUNC_CLR_ALL   = 2'd3;

    // request classes
    localparam logic [1:0] CLS_QUERY = 2'd0;
    localparam logic [1:0] CLS_WRITE = 2'd1;
    localparam logic [1:0] CLS_DDL   = 2'd2;

    localparam logic [2:0] TIER_WRITE = 3'd3;
    localparam logic [2:0] TIER_DDL   = 3'd4;

    // register indexes
    localparam logic [CFG_W-1:0] REG_QUERY_MIN  = CFG_W'(0);
    localparam logic [CFG_W-1:0] REG_QUERY_HOUR = CFG_W'(1);
    localparam logic [CFG_W-1:0] REG_WRITE_MIN  = CFG_W'(2);
    localparam logic [CFG_W-1:0] REG_DDL_MIN    = CFG_W'(3);

    typedef struct packed {
        logic [FILL_W-1:0]  cnt;
        logic [STAMP_W-1:0] oldest;
    } t_win_acc;

    typedef struct packed {
        logic in_min;
        logic in_hour;
    } t_win_hit;

    // wrap a slot sum that stays below twice the ring size
    function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SLOT_W:0] s);
        logic [SLOT_W:0] r;
        r = s;
        if (s >= (SLOT_W+1)'(RING_SLOTS)) begin
            r = s - (SLOT_W+1)'(RING_SLOTS);
        end
        return r[SLOT_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [RING_W-1:0] ring,
                                                   input logic [SLOT_W-1:0] slot);
        return ADDR_W'(ring) * ADDR_W'(RING_SLOTS) + ADDR_W'(slot);
    endfunction

    // win - (now - oldest), saturated to 1..RETRY_MAX
    function automatic logic [RETRY_W-1:0] sat_retry(input logic [STAMP_W-1:0] win,
                                                     input logic [STAMP_W-1:0] now,
                                                     input logic [STAMP_W-1:0] oldest);
        logic signed [STAMP_W+1:0] d;
        logic signed [STAMP_W+1:0] r;
        logic [RETRY_W-1:0]        q;
        d = $signed({2'b00, now}) - $signed({2'b00, oldest});
        r = $signed({2'b00, win}) - d;
        if (r < 1) begin
            q = RETRY_W'(1);
        end else if (r > $signed((STAMP_W+2)'(RETRY_MAX))) begin
            q = RETRY_MAX;
        end else begin
            q = r[RETRY_W-1:0];
        end
        return q;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/sliding_window_log_rate_limiter_core.sv]
`default_nettype none
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+-------------------------------------
// request  | in        | i_valid / o_ready  | i_func, i_client, i_tier, i_now_seconds
// response | out       | o_valid / i_ready  | o_allowed, o_retry_after
// config   | in        | i_cfg_we           | i_cfg_index, i_cfg_data
//
// a check scans the ring's stamps between transfer and response: one stamp read a cycle
// a record writes its stamp, then drops stale head stamps one by one; client resets go straight to done
// o_ready is high only in idle, entered in the cycle after the response is loaded
// a response left waiting in the output register holds the core in done
// synchronous active-low reset restores the default limits and clears ring heads and fill counts at once
module sliding_window_log_rate_limiter_core
    import swlrl_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_func,
    input  wire logic [2:0]         i_client,
    input  wire logic [2:0]         i_tier,
    input  wire logic [STAMP_W-1:0] i_now_seconds,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_allowed,
    output logic [RETRY_W-1:0]      o_retry_after,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_W-1:0]   i_cfg_index,
    input  wire logic [LIMIT_W-1:0] i_cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_WRITE = 6'b000100,
        ST_CLRD  = 6'b001000,
        ST_CLCMP = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [LIMIT_W-1:0] r_lim_qm, r_lim_qh, r_lim_wm, r_lim_dm;
    logic [SLOT_W-1:0]  r_head [RINGS];
    logic [FILL_W-1:0]  r_fill [RINGS];

    logic [1:0]         r_func;
    logic [1:0]         r_cls;
    logic [RING_W-1:0]  r_ring;
    logic               r_ok;
    logic [STAMP_W-1:0] r_now;
    logic [FILL_W-1:0]  r_idx, n_idx;
    logic               r_pend, n_pend;

    logic               r_out_valid;
    logic               r_out_allowed;
    logic [RETRY_W-1:0] r_out_retry;

    logic [1:0]         in_cls;
    logic               in_ok_client, in_ok_tier;
    logic [SLOT_W-1:0]  cur_head;
    logic [FILL_W-1:0]  cur_fill;
    logic [ADDR_W-1:0]  rd_addr, wr_addr;
    logic               mem_we;
    logic [STAMP_W-1:0] rd_data;
    logic               acc_clear, acc_en;
    t_win_hit           hit;
    t_win_acc           acc_min, acc_hour;
    logic               stale;
    logic [LIMIT_W-1:0] lim_min;
    logic [RETRY_W-1:0] retry;
    logic               out_load;

    // request decode
    always_comb begin
        in_cls       = (i_tier == TIER_WRITE) ? CLS_WRITE :
                       (i_tier == TIER_DDL)   ? CLS_DDL   : CLS_QUERY;
        in_ok_client = int'(i_client) < CLIENTS;
        in_ok_tier   = i_tier <= TIER_DDL;
    end

    assign cur_head = r_head[r_ring];
    assign cur_fill = r_fill[r_ring];

    // stamp memory addressing
    always_comb begin
        rd_addr = mem_addr(r_ring, slot_wrap({1'b0, cur_head} + (SLOT_W+1)'(r_idx)));
        if (r_state == ST_CLRD) begin
            rd_addr = mem_addr(r_ring, cur_head);
        end
        if (cur_fill >= FILL_W'(RING_SLOTS)) begin
            wr_addr = mem_addr(r_ring, cur_head);
        end else begin
            wr_addr = mem_addr(r_ring, slot_wrap({1'b0, cur_head} + (SLOT_W+1)'(cur_fill)));
        end
        mem_we = (r_state == ST_WRITE);
    end

    swlrl_ram #(
        .WIDTH(STAMP_W),
        .DEPTH(MEM_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(wr_addr),
        .i_wdata(r_now),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    assign acc_clear = (r_state == ST_IDLE);
    assign acc_en    = (r_state == ST_SCAN) && r_pend;

    swlrl_acc u_acc (
        .i_clk  (i_clk),
        .i_clear(acc_clear),
        .i_en   (acc_en),
        .i_now  (r_now),
        .i_stamp(rd_data),
        .o_hit  (hit),
        .o_min  (acc_min),
        .o_hour (acc_hour)
    );

    assign stale = (r_cls == CLS_QUERY) ? !hit.in_hour : !hit.in_min;

    // verdict from the two window counts
    always_comb begin
        case (r_cls)
            CLS_QUERY: lim_min = r_lim_qm;
            CLS_WRITE: lim_min = r_lim_wm;
            default:   lim_min = r_lim_dm;
        endcase
        retry = '0;
        if (r_func == FUNC_CHECK && r_ok) begin
            if (32'(acc_min.cnt) >= 32'(lim_min)) begin
                retry = sat_retry(MINUTE_WIN, r_now, acc_min.oldest);
            end else if (r_cls == CLS_QUERY && 32'(acc_hour.cnt) >= 32'(r_lim_qh)) begin
                retry = sat_retry(HOUR_WIN, r_now, acc_hour.oldest);
            end
        end
    end

    assign out_load = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_pend  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (i_valid) begin
                    if (i_func == FUNC_CHECK && in_ok_client && in_ok_tier) begin
                        n_state = ST_SCAN;
                    end else if (i_func == FUNC_RECORD && in_ok_client && in_ok_tier) begin
                        n_state = ST_WRITE;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (r_idx < cur_fill) begin
                    n_idx  = r_idx + FILL_W'(1);
                    n_pend = 1'b1;
                end else if (!r_pend) begin
                    n_state = ST_DONE;
                end
            end
            ST_WRITE: n_state = ST_CLRD;
            ST_CLRD:  n_state = ST_CLCMP;
            ST_CLCMP: begin
                if (cur_fill != '0 && stale) begin
                    n_state = ST_CLRD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
        end
    end

    // latch the request on transfer
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_func <= i_func;
            r_cls  <= in_cls;
            r_ring <= RING_W'(int'(i_client) * 3 + int'(in_cls));
            r_ok   <= in_ok_client && in_ok_tier;
            r_now  <= i_now_seconds;
        end
    end

    // limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_qm <= LIMIT_W'(60);
            r_lim_qh <= LIMIT_W'(1000);
            r_lim_wm <= LIMIT_W'(10);
            r_lim_dm <= LIMIT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_QUERY_MIN:  r_lim_qm <= i_cfg_data;
                REG_QUERY_HOUR: r_lim_qh <= i_cfg_data;
                REG_WRITE_MIN:  r_lim_wm <= i_cfg_data;
                REG_DDL_MIN:    r_lim_dm <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ring heads and fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RINGS; k++) begin
                r_head[k] <= '0;
                r_fill[k] <= '0;
            end
        end else if (r_state == ST_IDLE && i_valid && i_func == FUNC_CLR_ALL) begin
            for (int k = 0; k < RINGS; k++) begin
                r_head[k] <= '0;
                r_fill[k] <= '0;
            end
        end else if (r_state == ST_IDLE && i_valid && i_func == FUNC_CLR_ONE && in_ok_client) begin
            for (int k = 0; k < 3; k++) begin
                r_head[RING_W'(int'(i_client) * 3 + k)] <= '0;
                r_fill[RING_W'(int'(i_client) * 3 + k)] <= '0;
            end
        end else if (r_state == ST_WRITE) begin
            if (cur_fill >= FILL_W'(RING_SLOTS)) begin
                r_head[r_ring] <= slot_wrap({1'b0, cur_head} + (SLOT_W+1)'(1));
            end else begin
                r_fill[r_ring] <= cur_fill + FILL_W'(1);
            end
        end else if (r_state == ST_CLCMP && cur_fill != '0 && stale) begin
            r_head[r_ring] <= slot_wrap({1'b0, cur_head} + (SLOT_W+1)'(1));
            r_fill[r_ring] <= cur_fill - FILL_W'(1);
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_allowed <= (retry == '0);
            r_out_retry   <= retry;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_allowed     = r_out_allowed;
    assign o_retry_after = r_out_retry;

endmodule
`default_nettype wire

[hw/rtl/swlrl_ram.sv]
`default_nettype none
module swlrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[hw/rtl/swlrl_acc.sv]
`default_nettype none
module swlrl_acc
    import swlrl_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_clear,
    input  wire logic               i_en,
    input  wire logic [STAMP_W-1:0] i_now,
    input  wire logic [STAMP_W-1:0] i_stamp,
    output t_win_hit                o_hit,
    output t_win_acc                o_min,
    output t_win_acc                o_hour
);

    t_win_acc r_min, r_hour, n_min, n_hour;
    logic     r_have_min, r_have_hour, n_have_min, n_have_hour;

    // window compare: early time puts every stamp inside the window
    always_comb begin
        o_hit.in_min  = (i_now < MINUTE_WIN) || (i_stamp > i_now - MINUTE_WIN);
        o_hit.in_hour = (i_now < HOUR_WIN)   || (i_stamp > i_now - HOUR_WIN);
    end

    // count and oldest stamp per window
    always_comb begin
        n_min       = r_min;
        n_hour      = r_hour;
        n_have_min  = r_have_min;
        n_have_hour = r_have_hour;
        if (i_clear) begin
            n_min       = '{cnt: '0, oldest: i_now};
            n_hour      = '{cnt: '0, oldest: i_now};
            n_have_min  = 1'b0;
            n_have_hour = 1'b0;
        end else if (i_en) begin
            if (o_hit.in_min) begin
                n_min.cnt  = r_min.cnt + FILL_W'(1);
                n_have_min = 1'b1;
                if (!r_have_min || i_stamp < r_min.oldest) begin
                    n_min.oldest = i_stamp;
                end
            end
            if (o_hit.in_hour) begin
                n_hour.cnt  = r_hour.cnt + FILL_W'(1);
                n_have_hour = 1'b1;
                if (!r_have_hour || i_stamp < r_hour.oldest) begin
                    n_hour.oldest = i_stamp;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_min       <= n_min;
        r_hour      <= n_hour;
        r_have_min  <= n_have_min;
        r_have_hour <= n_have_hour;
    end

    // an empty window reports the current time as its oldest stamp
    assign o_min  = '{cnt: r_min.cnt,  oldest: r_have_min  ? r_min.oldest  : i_now};
    assign o_hour = '{cnt: r_hour.cnt, oldest: r_have_hour ? r_hour.oldest : i_now};

endmodule
`default_nettype wire

[sim/tb_sliding_window_log_rate_limiter_core.sv]
`timescale 1ns / 1ps

module tb_sliding_window_log_rate_limiter_core;
    import swlrl_pkg::*;

    localparam int  IDLE_MAX    = 6;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  DRAIN_WAIT  = RING_SLOTS + 16;
    localparam logic [CFG_W-1:0] REG_SPARE = CFG_W'(4);

    // limiter state mirror and queue of expected responses
    class rate_scoreboard;
        logic [STAMP_W-1:0] stamps[RINGS][RING_SLOTS];
        int unsigned        head[RINGS];
        int unsigned        fill[RINGS];
        int unsigned        limit_reg[4];
        bit                 want_allowed[$];
        logic [RETRY_W-1:0] want_retry[$];
        int                 mismatches;
        int                 checked;
        int                 denials;

        function new();
            limit_reg[REG_QUERY_MIN]  = 60;
            limit_reg[REG_QUERY_HOUR] = 1000;
            limit_reg[REG_WRITE_MIN]  = 10;
            limit_reg[REG_DDL_MIN]    = 1;
            for (int c = 0; c < CLIENTS; c++) clear_client(c);
        endfunction

        function void clear_client(int c);
            for (int k = 0; k < 3; k++) begin
                head[c*3+k] = 0;
                fill[c*3+k] = 0;
            end
        endfunction

        function void write_reg(logic [CFG_W-1:0] idx, logic [LIMIT_W-1:0] val);
            if (idx <= REG_DDL_MIN) limit_reg[idx] = val;
        endfunction

        // retry for one window, 0 when under the limit
        function logic [RETRY_W-1:0] window_retry(int ring, logic [STAMP_W-1:0] now,
                                                  longint win, int unsigned lim);
            longint      cutoff;
            longint      r;
            int unsigned n;
            logic [STAMP_W-1:0] t;
            logic [STAMP_W-1:0] oldest;
            bit          seen;
            cutoff = longint'(now) - win;
            n = 0;
            seen = 0;
            oldest = now;
            for (int i = 0; i < fill[ring]; i++) begin
                t = stamps[ring][(head[ring] + i) % RING_SLOTS];
                if (longint'(t) > cutoff) begin
                    n++;
                    if (!seen || t < oldest) begin
                        oldest = t;
                        seen = 1;
                    end
                end
            end
            if (n < lim) return '0;
            r = win - (longint'(now) - longint'(oldest));
            if (r < 1) r = 1;
            if (r > RETRY_MAX) r = RETRY_MAX;
            return RETRY_W'(r);
        endfunction

        function void append_stamp(int ring, logic [STAMP_W-1:0] now, longint max_age);
            longint cutoff;
            cutoff = longint'(now) - max_age;
            if (fill[ring] >= RING_SLOTS) begin
                stamps[ring][head[ring]] = now;
                head[ring] = (head[ring] + 1) % RING_SLOTS;
            end else begin
                stamps[ring][(head[ring] + fill[ring]) % RING_SLOTS] = now;
                fill[ring]++;
            end
            while (fill[ring] > 0 && longint'(stamps[ring][head[ring]]) <= cutoff) begin
                head[ring] = (head[ring] + 1) % RING_SLOTS;
                fill[ring]--;
            end
        endfunction

        function void note_request(logic [1:0] func, logic [2:0] client,
                                   logic [2:0] tier, logic [STAMP_W-1:0] now);
            logic [1:0]         cls;
            logic [RETRY_W-1:0] retry;
            bit                 usable;
            int                 ring;
            cls = (tier <= 3'd2) ? CLS_QUERY : ((tier == TIER_WRITE) ? CLS_WRITE : CLS_DDL);
            ring = int'(client) * 3 + int'(cls);
            usable = (client < CLIENTS) && (tier <= TIER_DDL);
            retry = '0;
            case (func)
                FUNC_CHECK: begin
                    if (usable) begin
                        if (cls == CLS_QUERY) begin
                            retry = window_retry(ring, now, MINUTE_WIN, limit_reg[REG_QUERY_MIN]);
                            if (retry == 0)
                                retry = window_retry(ring, now, HOUR_WIN,
                                                     limit_reg[REG_QUERY_HOUR]);
                        end else begin
                            retry = window_retry(ring, now, MINUTE_WIN,
                                                 (cls == CLS_WRITE) ? limit_reg[REG_WRITE_MIN]
                                                                    : limit_reg[REG_DDL_MIN]);
                        end
                    end
                end
                FUNC_RECORD: begin
                    if (usable)
                        append_stamp(ring, now, (cls == CLS_QUERY) ? HOUR_WIN : MINUTE_WIN);
                end
                FUNC_CLR_ONE: begin
                    if (client < CLIENTS) clear_client(client);
                end
                default: begin
                    for (int c = 0; c < CLIENTS; c++) clear_client(c);
                end
            endcase
            if (retry != 0) denials++;
            want_allowed.push_back(retry == 0);
            want_retry.push_back(retry);
        endfunction

        function void check_response(logic allowed, logic [RETRY_W-1:0] retry);
            bit                 e_allowed;
            logic [RETRY_W-1:0] e_retry;
            if (want_allowed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: allowed %0d retry %0d", allowed, retry);
                return;
            end
            e_allowed = want_allowed.pop_front();
            e_retry = want_retry.pop_front();
            checked++;
            if (allowed !== e_allowed || retry !== e_retry) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response %0d mismatch: allowed exp %0d got %0d, retry exp %0d got %0d",
                             checked, e_allowed, allowed, e_retry, retry);
            end
        endfunction

        function int pending();
            return want_allowed.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_func;
    logic [2:0]         i_client;
    logic [2:0]         i_tier;
    logic [STAMP_W-1:0] i_now_seconds;
    logic               o_valid;
    logic               i_ready;
    logic               o_allowed;
    logic [RETRY_W-1:0] o_retry_after;
    logic               i_cfg_we;
    logic [CFG_W-1:0]   i_cfg_index;
    logic [LIMIT_W-1:0] i_cfg_data;

    rate_scoreboard     limiter_sb;
    bit                 no_idle;
    int                 resp_hold;
    int                 cycle_count;
    logic [STAMP_W-1:0] clock_now;

    sliding_window_log_rate_limiter_core dut (.*);

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // response side: random stall per transfer, checked against the queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            resp_hold = 0;
        end else if (o_valid && i_ready) begin
            limiter_sb.check_response(o_allowed, o_retry_after);
            resp_hold = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
            i_ready <= (resp_hold == 0);
        end else if (resp_hold > 0) begin
            resp_hold--;
            i_ready <= (resp_hold == 0);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("sliding_window_log_rate_limiter_core test failed");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] func, logic [2:0] client, logic [2:0] tier,
                                logic [STAMP_W-1:0] now);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_func        <= func;
        i_client      <= client;
        i_tier        <= tier;
        i_now_seconds <= now;
        i_valid       <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        limiter_sb.note_request(func, client, tier, now);
    endtask

    // let every response drain, then register writes are safe
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (limiter_sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // write enable stays high across back-to-back writes, the caller drops it
    task automatic write_reg(logic [CFG_W-1:0] idx, logic [LIMIT_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        limiter_sb.write_reg(idx, val);
    endtask

    task automatic set_limits(int qm, int qh, int wm, int dm);
        wait_idle();
        write_reg(REG_QUERY_MIN, LIMIT_W'(qm));
        write_reg(REG_QUERY_HOUR, LIMIT_W'(qh));
        write_reg(REG_WRITE_MIN, LIMIT_W'(wm));
        write_reg(REG_DDL_MIN, LIMIT_W'(dm));
        write_reg(REG_SPARE + CFG_W'($urandom_range(0, 3)), LIMIT_W'($urandom));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // random traffic around a moving time base
    task automatic random_burst(int count, logic [STAMP_W-1:0] base);
        logic [1:0]         func;
        logic [2:0]         client;
        logic [2:0]         tier;
        logic [STAMP_W-1:0] now;
        int                 pick;
        clock_now = base;
        send_request(FUNC_CLR_ALL, 3'($urandom), 3'($urandom), clock_now);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            func = (pick < 45) ? FUNC_CHECK : (pick < 92) ? FUNC_RECORD :
                   (pick < 97) ? FUNC_CLR_ONE : FUNC_CLR_ALL;
            client = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(0, 2));
            tier = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4));
            pick = $urandom_range(0, 99);
            if (pick < 3)
                clock_now = clock_now + $urandom_range(61, 4000);
            else
                clock_now = clock_now + $urandom_range(0, 12);
            now = clock_now;
            // occasional stale time stamp
            if ($urandom_range(0, 24) == 0) now = clock_now - $urandom_range(1, 200);
            send_request(func, client, tier, now);
            if (n % 40 == 39) no_idle = !no_idle;
        end
        no_idle = 0;
    endtask

    initial begin
        limiter_sb = new();
        no_idle = 0;
        cycle_count = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = FUNC_CHECK;
        i_client = '0;
        i_tier = '0;
        i_now_seconds = '0;
        i_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_QUERY_MIN;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset limits, windows, odd tiers and clients, clears
        send_request(FUNC_CHECK,  3'd0, 3'd0, 32'd0);
        send_request(FUNC_RECORD, 3'd0, TIER_DDL, 32'd5);
        send_request(FUNC_CHECK,  3'd0, TIER_DDL, 32'd10);
        send_request(FUNC_CHECK,  3'd0, TIER_DDL, 32'd65);
        send_request(FUNC_CHECK,  3'd0, TIER_DDL, 32'd64);
        send_request(FUNC_RECORD, 3'd7, 3'd7, 32'd70);
        send_request(FUNC_CHECK,  3'd7, 3'd5, 32'd70);
        send_request(FUNC_CHECK,  3'd7, 3'd6, 32'd70);
        send_request(FUNC_RECORD, 3'd7, TIER_WRITE, 32'd100);
        send_request(FUNC_CHECK,  3'd7, TIER_WRITE, 32'd50);
        send_request(FUNC_RECORD, 3'd7, TIER_DDL, 32'd100);
        send_request(FUNC_CHECK,  3'd7, TIER_DDL, 32'd40);
        send_request(FUNC_CLR_ONE, 3'd7, 3'd0, 32'd100);
        send_request(FUNC_CHECK,  3'd7, TIER_DDL, 32'd100);
        send_request(FUNC_CHECK,  3'd0, TIER_DDL, 32'hFFFF_FFFF);
        send_request(FUNC_CLR_ALL, 3'd5, 3'd2, 32'hFFFF_FFFF);

        // zero limits and the hour window
        set_limits(0, 2, 0, 0);
        send_request(FUNC_CHECK,  3'd2, 3'd1, 32'd1000);
        send_request(FUNC_CHECK,  3'd2, TIER_WRITE, 32'd1000);
        set_limits(5, 2, 1, 0);
        send_request(FUNC_RECORD, 3'd3, 3'd1, 32'd1000);
        send_request(FUNC_RECORD, 3'd3, 3'd2, 32'd2000);
        send_request(FUNC_CHECK,  3'd3, 3'd0, 32'd3000);
        send_request(FUNC_CHECK,  3'd3, 3'd0, 32'd4600);
        send_request(FUNC_CHECK,  3'd3, 3'd0, 32'd4700);

        // random phases across limit settings and time ranges
        set_limits(3, 6, 2, 1);
        random_burst(110, 32'd0);
        set_limits(0, 0, 0, 0);
        random_burst(60, $urandom);
        set_limits(1024, 1024, 1024, 1024);
        random_burst(90, $urandom);
        set_limits(2047, 2047, 2047, 2047);
        random_burst(60, 32'hFFFF_F000);
        set_limits($urandom_range(0, 8), $urandom_range(0, 12), $urandom_range(0, 6),
                   $urandom_range(0, 3));
        random_burst(110, 32'h0001_0000);
        set_limits(1, 1024, 3, 2);
        random_burst(110, $urandom);

        i_valid <= 1'b0;
        while (limiter_sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("checked %0d responses, %0d of them denials", limiter_sb.checked,
                 limiter_sb.denials);
        $display("mismatches: %0d", limiter_sb.mismatches);
        if (limiter_sb.mismatches == 0)
            $display("sliding_window_log_rate_limiter_core test passed");
        else
            $display("sliding_window_log_rate_limiter_core test failed");
        $finish;
    end

endmodule

[sliding_window_log_rate_limiter_core.f]
hw/rtl/swlrl_pkg.sv
hw/rtl/swlrl_ram.sv
hw/rtl/swlrl_acc.sv
hw/rtl/sliding_window_log_rate_limiter_core.sv
sim/tb_sliding_window_log_rate_limiter_core.sv
